[hw/rtl/tua_pkg.sv]
// Shared types and constants for the tagged unsigned ALU.
// Used by tua_div and tagged_unsigned_alu; no dependencies.
`default_nettype none
package tua_pkg;

   localparam int VALUE_BITS = 32;
   localparam int LO_BITS    = VALUE_BITS / 2;
   localparam int HI_BITS    = VALUE_BITS - LO_BITS;
   // accept edge to the edge that takes the result
   localparam int LATENCY    = VALUE_BITS + 2;

   typedef enum logic [3:0] {
      CMD_ADD = 4'd0,
      CMD_SUB = 4'd1,
      CMD_MUL = 4'd2,
      CMD_DIV = 4'd3,
      CMD_MOD = 4'd4,
      CMD_EQ  = 4'd5,
      CMD_NE  = 4'd6,
      CMD_LT  = 4'd7,
      CMD_GT  = 4'd8,
      CMD_LE  = 4'd9,
      CMD_GE  = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      TAG_NUM = 2'd0,
      TAG_INF = 2'd1,
      TAG_NAN = 2'd2
   } tag_type;

   typedef enum logic [1:0] {
      SEL_FIXED = 2'd0,
      SEL_MUL   = 2'd1,
      SEL_QUO   = 2'd2,
      SEL_REM   = 2'd3
   } sel_type;

   typedef struct packed {
      logic [3:0]            command;
      logic [1:0]            a_kind;
      logic [VALUE_BITS-1:0] a_value;
      logic [1:0]            b_kind;
      logic [VALUE_BITS-1:0] b_value;
   } req_type;

   typedef struct packed {
      logic [1:0]            result_kind;
      logic [VALUE_BITS-1:0] result_value;
      logic                  compare_true;
   } rsp_type;

   // result fields that ride alongside the divider stages
   typedef struct packed {
      logic                  valid;
      tag_type               kind;
      logic [VALUE_BITS-1:0] value;
      logic                  cmp;
      sel_type               sel;
      logic [VALUE_BITS-1:0] mul_lo;
      logic [HI_BITS-1:0]    mul_cross;
   } side_type;

endpackage
`default_nettype wire

[hw/rtl/tua_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tua_pkg for VALUE_BITS.
`default_nettype none
module tua_div (
   input  wire logic                           clock,
   input  wire logic [tua_pkg::VALUE_BITS-1:0] num,
   input  wire logic [tua_pkg::VALUE_BITS-1:0] den,
   output logic      [tua_pkg::VALUE_BITS-1:0] quo,
   output logic      [tua_pkg::VALUE_BITS-1:0] rem
);
   import tua_pkg::*;

   logic [VALUE_BITS-1:0] rem_ff [VALUE_BITS];
   logic [VALUE_BITS-1:0] quo_ff [VALUE_BITS];
   logic [VALUE_BITS-1:0] den_ff [VALUE_BITS];
   logic [VALUE_BITS-1:0] rem_in [VALUE_BITS];
   logic [VALUE_BITS-1:0] quo_in [VALUE_BITS];
   logic [VALUE_BITS-1:0] den_in [VALUE_BITS];

   always_comb begin
      logic [VALUE_BITS-1:0] r_prev;
      logic [VALUE_BITS-1:0] n_prev;
      logic [VALUE_BITS-1:0] d_prev;
      logic [VALUE_BITS:0]   trial;
      logic [VALUE_BITS:0]   diff;
      logic                  fits;
      for (int s = 0; s < VALUE_BITS; s++) begin
         if (s == 0) begin
            r_prev = '0;
            n_prev = num;
            d_prev = den;
         end else begin
            r_prev = rem_ff[s-1];
            n_prev = quo_ff[s-1];
            d_prev = den_ff[s-1];
         end
         // shift in the next dividend bit, subtract when it fits
         trial = {r_prev, n_prev[VALUE_BITS-1]};
         diff  = trial - {1'b0, d_prev};
         fits  = (trial >= {1'b0, d_prev});
         rem_in[s] = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
         quo_in[s] = {n_prev[VALUE_BITS-2:0], fits};
         den_in[s] = d_prev;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < VALUE_BITS; s++) begin
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         den_ff[s] <= den_in[s];
      end
   end

   assign quo = quo_ff[VALUE_BITS-1];
   assign rem = rem_ff[VALUE_BITS-1];

endmodule
`default_nettype wire

[hw/rtl/tagged_unsigned_alu.sv]
// Top level of the tagged unsigned ALU: decode, multiplier, divider, result.
// Depends on tua_pkg and tua_div.
//
// Usage:
//   Drive req_data and raise start for one cycle per request; busy is
//   always low, so a request is taken at every edge with start high and
//   a new one may follow in every cycle.
//   Each request yields one result on rsp_data, shown for exactly one cycle
//   with rsp_valid high; results leave in request order. A request passes
//   through an input register, the divider with one quotient bit per
//   pipeline stage, and an output register. Every command takes the same
//   path length, so throughput is one request per cycle.
//   The receiver cannot stall; rsp_valid is a strobe and must be taken.
//   Synchronous reset clears the valid bits of all stages; requests in
//   flight are dropped and no result appears for them.
`default_nettype none
module tagged_unsigned_alu (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tua_pkg::req_type req_data,
   output logic                  rsp_valid,
   output tua_pkg::rsp_type      rsp_data
);
   import tua_pkg::*;

   // input stage: normalized operands
   logic                  s0_valid_ff;
   logic [3:0]            s0_cmd_ff;
   tag_type               s0_a_tag_ff, s0_b_tag_ff;
   logic [VALUE_BITS-1:0] s0_a_ff, s0_b_ff;
   tag_type               a_tag_in, b_tag_in;

   side_type side_ff [VALUE_BITS];
   side_type side_in [VALUE_BITS];

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [VALUE_BITS-1:0] div_quo, div_rem;

   assign busy = 1'b0;

   always_comb begin
      case (req_data.a_kind)
         TAG_NUM: a_tag_in = TAG_NUM;
         TAG_INF: a_tag_in = TAG_INF;
         default: a_tag_in = TAG_NAN;
      endcase
      case (req_data.b_kind)
         TAG_NUM: b_tag_in = TAG_NUM;
         TAG_INF: b_tag_in = TAG_INF;
         default: b_tag_in = TAG_NAN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
      s0_cmd_ff   <= req_data.command;
      s0_a_tag_ff <= a_tag_in;
      s0_b_tag_ff <= b_tag_in;
      s0_a_ff     <= (a_tag_in == TAG_NUM) ? req_data.a_value : '0;
      s0_b_ff     <= (b_tag_in == TAG_NUM) ? req_data.b_value : '0;
   end

   tua_div u_div (
      .clock (clock),
      .num   (s0_a_ff),
      .den   (s0_b_ff),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // first side stage: tag rules, add/sub, compare, partial products
   always_comb begin
      logic any_nan, a_inf, b_inf, a_zero, b_zero, lt, gt, eq;
      logic [LO_BITS-1:0] a_lo, b_lo;
      logic [HI_BITS-1:0] a_hi, b_hi;
      logic [2*LO_BITS-1:0] p_ll;
      logic [HI_BITS-1:0]   p_x;
      any_nan = (s0_a_tag_ff == TAG_NAN) || (s0_b_tag_ff == TAG_NAN);
      a_inf   = (s0_a_tag_ff == TAG_INF);
      b_inf   = (s0_b_tag_ff == TAG_INF);
      a_zero  = (s0_a_tag_ff == TAG_NUM) && (s0_a_ff == '0);
      b_zero  = (s0_b_tag_ff == TAG_NUM) && (s0_b_ff == '0);
      lt = (!a_inf && b_inf) || (!a_inf && !b_inf && (s0_a_ff < s0_b_ff));
      gt = (a_inf && !b_inf) || (!a_inf && !b_inf && (s0_a_ff > s0_b_ff));
      eq = !lt && !gt;
      a_lo = s0_a_ff[LO_BITS-1:0];
      b_lo = s0_b_ff[LO_BITS-1:0];
      a_hi = s0_a_ff[VALUE_BITS-1:LO_BITS];
      b_hi = s0_b_ff[VALUE_BITS-1:LO_BITS];
      p_ll = {{LO_BITS{1'b0}}, a_lo} * {{LO_BITS{1'b0}}, b_lo};
      p_x  = HI_BITS'(a_hi * HI_BITS'(b_lo)) + HI_BITS'(HI_BITS'(a_lo) * b_hi);

      side_in[0].valid     = s0_valid_ff;
      side_in[0].kind      = TAG_NUM;
      side_in[0].value     = '0;
      side_in[0].cmp       = 1'b0;
      side_in[0].sel       = SEL_FIXED;
      side_in[0].mul_lo    = VALUE_BITS'(p_ll);
      side_in[0].mul_cross = p_x;

      case (s0_cmd_ff)
         CMD_ADD, CMD_SUB: begin
            if (any_nan) side_in[0].kind = TAG_NAN;
            else if (a_inf || b_inf) side_in[0].kind = TAG_INF;
            else if (s0_cmd_ff == CMD_ADD) side_in[0].value = s0_a_ff + s0_b_ff;
            else side_in[0].value = s0_a_ff - s0_b_ff;
         end
         CMD_MUL: begin
            if (any_nan) side_in[0].kind = TAG_NAN;
            else if (b_inf) side_in[0].kind = a_zero ? TAG_NAN : TAG_INF;
            else if (a_inf) side_in[0].kind = b_zero ? TAG_NAN : TAG_INF;
            else side_in[0].sel = SEL_MUL;
         end
         CMD_DIV: begin
            if (any_nan || b_zero) side_in[0].kind = TAG_NAN;
            else if (b_inf) side_in[0].kind = a_inf ? TAG_NAN : TAG_NUM;
            else if (a_inf) side_in[0].kind = TAG_INF;
            else side_in[0].sel = SEL_QUO;
         end
         CMD_MOD: begin
            if (any_nan || b_zero) side_in[0].kind = TAG_NAN;
            else if (b_inf) side_in[0].value = s0_a_ff;
            else if (!a_inf) side_in[0].sel = SEL_REM;
         end
         CMD_EQ: side_in[0].cmp = !any_nan && eq;
         CMD_NE: side_in[0].cmp = !any_nan && !eq;
         CMD_LT: side_in[0].cmp = !any_nan && lt;
         CMD_GT: side_in[0].cmp = !any_nan && gt;
         CMD_LE: side_in[0].cmp = !any_nan && !gt;
         CMD_GE: side_in[0].cmp = !any_nan && !lt;
         default: ;
      endcase

      // later stages: finish the product in stage two, then hold
      for (int s = 1; s < VALUE_BITS; s++) begin
         side_in[s] = side_ff[s-1];
         if (side_ff[s-1].sel == SEL_MUL) begin
            side_in[s].value = side_ff[s-1].mul_lo
                             + {side_ff[s-1].mul_cross, {LO_BITS{1'b0}}};
            side_in[s].sel   = SEL_FIXED;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < VALUE_BITS; s++) begin
         if (reset) begin
            side_ff[s].valid <= 1'b0;
         end else begin
            side_ff[s] <= side_in[s];
         end
      end
   end

   always_comb begin
      rsp_data_in.result_kind  = side_ff[VALUE_BITS-1].kind;
      rsp_data_in.compare_true = side_ff[VALUE_BITS-1].cmp;
      case (side_ff[VALUE_BITS-1].sel)
         SEL_QUO: rsp_data_in.result_value = div_quo;
         SEL_REM: rsp_data_in.result_value = div_rem;
         default: rsp_data_in.result_value = side_ff[VALUE_BITS-1].value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_ff[VALUE_BITS-1].valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request produced no result at the expected latency");
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching request");
   a_cmp_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.compare_true) |->
         (rsp_data.result_kind == TAG_NUM && rsp_data.result_value == '0))
      else $error("comparison result carries arithmetic fields");
   a_nonnum_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind != TAG_NUM) |-> rsp_data.result_value == '0)
      else $error("non-number result with nonzero value");

endmodule
`default_nettype wire

[tb/tagged_unsigned_alu_test.sv]
// Testbench for tagged_unsigned_alu: drives tagged operand requests and
// checks every result against an in-bench model of the tag rules.
// Depends on tua_pkg and the tagged_unsigned_alu RTL.
`timescale 1ns / 1ps
module tagged_unsigned_alu_test;
   import tua_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   tagged_unsigned_alu dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   req_type pending_requests[$];
   int      pending_gaps[$];
   rsp_type expected_results[$];
   int      mismatch_count;
   int      cycle_count;
   int      gap_left;
   bit      stimulus_done;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // compute the result one request must give
   function automatic rsp_type alu_result(req_type r);
      rsp_type  o;
      tag_type  ak, bk;
      logic [VALUE_BITS-1:0] av, bv;
      bit       any_nan, a_inf, b_inf, a_zero, b_zero;
      int       ord;
      ak = (r.a_kind == TAG_NUM) ? TAG_NUM : (r.a_kind == TAG_INF) ? TAG_INF : TAG_NAN;
      bk = (r.b_kind == TAG_NUM) ? TAG_NUM : (r.b_kind == TAG_INF) ? TAG_INF : TAG_NAN;
      av = (ak == TAG_NUM) ? r.a_value : '0;
      bv = (bk == TAG_NUM) ? r.b_value : '0;
      any_nan = (ak == TAG_NAN) || (bk == TAG_NAN);
      a_inf = (ak == TAG_INF);
      b_inf = (bk == TAG_INF);
      a_zero = (ak == TAG_NUM) && (av == 0);
      b_zero = (bk == TAG_NUM) && (bv == 0);
      o = '0;
      o.result_kind = TAG_NUM;
      case (r.command)
         CMD_ADD, CMD_SUB: begin
            if (any_nan) o.result_kind = TAG_NAN;
            else if (a_inf || b_inf) o.result_kind = TAG_INF;
            else o.result_value = (r.command == CMD_ADD) ? av + bv : av - bv;
         end
         CMD_MUL: begin
            if (any_nan) o.result_kind = TAG_NAN;
            else if (b_inf) o.result_kind = a_zero ? TAG_NAN : TAG_INF;
            else if (a_inf) o.result_kind = b_zero ? TAG_NAN : TAG_INF;
            else o.result_value = av * bv;
         end
         CMD_DIV: begin
            if (any_nan || b_zero) o.result_kind = TAG_NAN;
            else if (b_inf) begin
               if (a_inf) o.result_kind = TAG_NAN;
            end else if (a_inf) o.result_kind = TAG_INF;
            else o.result_value = av / bv;
         end
         CMD_MOD: begin
            if (any_nan || b_zero) o.result_kind = TAG_NAN;
            else if (b_inf) begin
               if (!a_inf) o.result_value = av;
            end else if (!a_inf) o.result_value = av % bv;
         end
         CMD_EQ, CMD_NE, CMD_LT, CMD_GT, CMD_LE, CMD_GE: begin
            if (!any_nan) begin
               if (a_inf && b_inf) ord = 0;
               else if (a_inf) ord = 1;
               else if (b_inf) ord = -1;
               else ord = (av < bv) ? -1 : (av > bv) ? 1 : 0;
               case (r.command)
                  CMD_EQ: o.compare_true = (ord == 0);
                  CMD_NE: o.compare_true = (ord != 0);
                  CMD_LT: o.compare_true = (ord < 0);
                  CMD_GT: o.compare_true = (ord > 0);
                  CMD_LE: o.compare_true = (ord <= 0);
                  default: o.compare_true = (ord >= 0);
               endcase
            end
         end
         default: ;
      endcase
      if (o.result_kind != TAG_NUM) o.result_value = '0;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [VALUE_BITS-1:0] got,
                                  logic [VALUE_BITS-1:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h",
               cycle_count, what, got, want);
      mismatch_count++;
   endtask

   function automatic int random_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_value();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return $urandom_range(9);
         3: return {1'b1, 31'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_request(logic [3:0] cmd, logic [1:0] ak,
                                logic [VALUE_BITS-1:0] av, logic [1:0] bk,
                                logic [VALUE_BITS-1:0] bv, int gap);
      req_type r;
      r.command = cmd;
      r.a_kind = ak;
      r.a_value = av;
      r.b_kind = bk;
      r.b_value = bv;
      pending_requests.push_back(r);
      pending_gaps.push_back(gap);
   endtask

   // a negative gap holds the sender until all results are back
   initial begin
      logic [1:0] ak, bk;
      for (int c = 0; c <= CMD_GE; c++) begin
         queue_request(4'(c), TAG_NUM, '1, TAG_NUM, '1, 0);
         queue_request(4'(c), TAG_NUM, '0, TAG_INF, 32'h5a5a_a5a5, 0);
      end
      queue_request(CMD_DIV, TAG_NUM, 32'd7, TAG_NUM, '0, 0);
      queue_request(CMD_MUL, TAG_INF, 32'hffff_ffff, TAG_NUM, '0, 0);
      queue_request(CMD_MOD, TAG_INF, '0, TAG_INF, '0, 0);
      queue_request(CMD_ADD, 2'd3, '1, TAG_NUM, 32'd1, 0);
      queue_request(4'd15, TAG_NUM, '1, TAG_NUM, '1, -1);
      for (int i = 0; i < 1800; i++) begin
         ak = ($urandom_range(9) < 6) ? TAG_NUM : 2'($urandom);
         bk = ($urandom_range(9) < 6) ? TAG_NUM : 2'($urandom);
         queue_request(($urandom_range(19) == 0) ? 4'($urandom)
                                                 : 4'($urandom_range(CMD_GE)),
                       ak, random_value(), bk, random_value(),
                       (i == 900) ? -1 : (i % 300 < 60) ? 0 : random_gap());
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
         stimulus_done <= 1'b0;
      end else if (start && busy) begin
         // hold the request until it is taken
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_requests.size() == 0) begin
         start <= 1'b0;
         stimulus_done <= 1'b1;
      end else if (pending_gaps[0] < 0 && (start || expected_results.size() != 0)) begin
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req_data <= pending_requests.pop_front();
         gap_left <= (pending_gaps[0] < 0) ? 0 : pending_gaps[0];
         void'(pending_gaps.pop_front());
      end
   end

   // record expectations at the accept edge, check strobed results
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) expected_results.push_back(alu_result(req_data));
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", '0, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.result_kind !== want.result_kind)
                  report_mismatch("result_kind", VALUE_BITS'(rsp_data.result_kind),
                                  VALUE_BITS'(want.result_kind));
               if (rsp_data.result_value !== want.result_value)
                  report_mismatch("result_value", rsp_data.result_value, want.result_value);
               if (rsp_data.compare_true !== want.compare_true)
                  report_mismatch("compare_true", VALUE_BITS'(rsp_data.compare_true),
                                  VALUE_BITS'(want.compare_true));
            end
         end
      end
   end

   initial begin
      mismatch_count = 0;
      cycle_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stimulus_done && expected_results.size() == 0);
            repeat (LATENCY + 10) @(posedge clock);
            if (expected_results.size() != 0) report_mismatch("results left over", '0, '0);
            if (mismatch_count == 0) $display("tagged_unsigned_alu test passed");
            else $display("tagged_unsigned_alu test failed");
         end
         begin
            while (cycle_count < CYCLE_LIMIT) begin
               @(posedge clock);
               cycle_count++;
            end
            $display("timeout after %0d cycles", cycle_count);
            $display("tagged_unsigned_alu test failed");
         end
      join_any
      $finish;
   end
endmodule
